// ----- rtl/srww_pkg.sv -----
// Shared types and constants of the soft-return word wrap block.
package srww_pkg;

  localparam int POSITION_BITS = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] SOFT_CR      = 8'd227;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] SPACE_BYTE   = 8'd32;
  localparam logic [7:0] ZERO_BYTE    = 8'd0;
  localparam logic [7:0] WRAP_RESET   = 8'd80;

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] out_position;
    logic        is_patch;
    logic        last_result;
  } out_item_t;

  // One classified input byte, waiting to be expanded into results.
  typedef struct packed {
    logic [7:0] byte_val;
    pos_t       pos;
    logic       patch;
    pos_t       patch_pos;
    logic       eot;
  } job_t;

endpackage

// ----- rtl/srww_front.sv -----
// Front part: accepts text bytes, tracks column and space, classifies each item.
module srww_front import srww_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       push,
  output job_t       push_job,
  input  logic       queue_full
);

  logic [7:0] wrap_column;
  pos_t       byte_position, byte_position_next;
  logic [7:0] column_count, column_count_next;
  pos_t       space_position, space_position_next;
  logic       space_valid, space_valid_next;
  logic       stopped, stopped_next;

  logic [7:0] col_inc;
  logic       is_space;
  pos_t       sp_sel;
  logic       sv_sel;
  pos_t       space_gap;

  assign in_ready  = !queue_full;
  assign cfg_ready = 1'b1;
  assign push      = in_valid && !queue_full;

  always_comb begin
    byte_position_next  = byte_position + pos_t'(1);
    column_count_next   = column_count;
    space_position_next = space_position;
    space_valid_next    = space_valid;
    stopped_next        = stopped;

    is_space  = (in_data.text_byte == SPACE_BYTE);
    col_inc   = (column_count < wrap_column) ? column_count + 8'd1 : column_count;
    sp_sel    = is_space ? byte_position : space_position;
    sv_sel    = space_valid || is_space;
    space_gap = byte_position - sp_sel;

    push_job.byte_val  = in_data.text_byte;
    push_job.pos       = byte_position;
    push_job.patch     = 1'b0;
    push_job.patch_pos = sp_sel;
    push_job.eot       = in_data.end_of_text;

    if (stopped || in_data.text_byte == ZERO_BYTE) begin
      // pass everything unchanged once a zero byte turns up
      stopped_next = 1'b1;
    end else if (in_data.text_byte == NEWLINE_BYTE) begin
      push_job.byte_val = SOFT_CR;
      column_count_next = 8'd0;
      space_valid_next  = 1'b0;
    end else begin
      column_count_next   = col_inc;
      space_position_next = sp_sel;
      space_valid_next    = sv_sel;
      if (col_inc >= wrap_column && sv_sel) begin
        space_valid_next = 1'b0;
        if (sp_sel == byte_position) begin
          push_job.byte_val = SOFT_CR;
          column_count_next = 8'd0;
        end else begin
          push_job.patch    = 1'b1;
          column_count_next = (space_gap < pos_t'(wrap_column)) ? space_gap[7:0] : wrap_column;
        end
      end
    end

    if (in_data.end_of_text) begin
      byte_position_next = '0;
      column_count_next  = 8'd0;
      space_valid_next   = 1'b0;
      stopped_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_column    <= WRAP_RESET;
      byte_position  <= '0;
      column_count   <= 8'd0;
      space_position <= '0;
      space_valid    <= 1'b0;
      stopped        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        wrap_column <= cfg_data;
      end
      if (push) begin
        byte_position  <= byte_position_next;
        column_count   <= column_count_next;
        space_position <= space_position_next;
        space_valid    <= space_valid_next;
        stopped        <= stopped_next;
      end
    end
  end

endmodule

// ----- rtl/srww_queue.sv -----
// Short queue of classified items between the front and back parts.
module srww_queue import srww_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full       = (count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_BITS + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_BITS + 1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_BITS + 1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ----- rtl/srww_back.sv -----
// Back part: expands each queued item into its results through an output register.
module srww_back import srww_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [1:0] PH_BYTE  = 2'd0;
  localparam logic [1:0] PH_PATCH = 2'd1;
  localparam logic [1:0] PH_TERM  = 2'd2;

  logic [1:0] phase, phase_next;
  logic       load;
  logic       done;
  out_item_t  result;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && done;

  always_comb begin
    result     = '0;
    phase_next = PH_BYTE;
    done       = 1'b1;
    unique case (phase)
      PH_BYTE: begin
        result.out_byte     = head_job.byte_val;
        result.out_position = 16'(head_job.pos);
        if (head_job.patch) begin
          phase_next = PH_PATCH;
          done       = 1'b0;
        end else if (head_job.eot) begin
          phase_next = PH_TERM;
          done       = 1'b0;
        end
      end
      PH_PATCH: begin
        result.out_byte     = SOFT_CR;
        result.out_position = 16'(head_job.patch_pos);
        result.is_patch     = 1'b1;
        if (head_job.eot) begin
          phase_next = PH_TERM;
          done       = 1'b0;
        end
      end
      PH_TERM: begin
        result.out_byte     = SOFT_CR;
        result.out_position = 16'(head_job.pos + pos_t'(1));
        result.last_result  = 1'b1;
      end
      default: begin
        phase_next = PH_BYTE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BYTE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_phase_has_item: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_BYTE) |-> head_valid)
    else $error("result phase advanced without a queued item");

  a_terminator_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last_result) |-> (out_data.out_byte == SOFT_CR && !out_data.is_patch))
    else $error("terminator result malformed");

  a_patch_follows: assert property (@(posedge clk) disable iff (rst)
    (load && phase == PH_BYTE && head_job.patch) |=> (phase == PH_PATCH))
    else $error("patch result skipped");

endmodule

// ----- rtl/soft_return_word_wrap.sv -----
// Top level of the soft-return word wrap block: front, queue and back joined.
//
//   channel  | handshake             | payload     | role
//   ---------+-----------------------+-------------+---------------------------------
//   in       | in_valid / in_ready   | in_item_t   | raw text bytes, end_of_text flag
//   out      | out_valid / out_ready | out_item_t  | body bytes, patches, terminator
//   cfg      | cfg_valid / cfg_ready | 8-bit data  | wrap_column register
//
// Each item yields one to three results: the converted byte, a patch that
// turns an earlier space into a soft return, and the terminator after the last
// byte. The front takes one item a cycle while the queue has room; the back
// drives one result a cycle through its output register while that register
// is empty or taken, and pops an item only with its last result. Reset is
// synchronous: it empties the queue and output register, clears the column
// and position tracking and sets wrap_column to 80. A stalled output fills
// the four-entry queue, and only then does in_ready fall.
module soft_return_word_wrap import srww_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  // front to queue
  logic push;
  job_t push_job;
  logic queue_full;

  // queue to back
  logic pop;
  logic head_valid;
  job_t head_job;

  // Classify each accepted byte and advance the column state.
  srww_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  // Hold classified items so that either side may stall on its own.
  srww_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Expand each item into its results, one per cycle while the output accepts them.
  srww_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
